### rtl/ppc_pkg.sv
// Shared constants and types for the pixel polynomial correction block.
// No dependencies; used by every module in rtl/.
package ppc_pkg;

  localparam int PIX_W          = 16;
  localparam int COEF_W         = 48;
  localparam int NUM_REGS       = 6;
  localparam int NUM_COEFFS_DEF = 4;
  localparam int CFG_DATA_W     = 64;
  localparam int IDX_W          = 3;
  localparam int ADDR_W         = IDX_W + 3;   // 8-byte register stride

  // Fixed point: coefficients are Q23.24, each Horner step adds 16 fraction bits
  localparam int COEF_FRAC_W    = 24;
  localparam int STEP_SHIFT     = 16;

  typedef logic [NUM_REGS-1:0][COEF_W-1:0] coef_arr_t;

  // coef_1 resets to slope one (2^40), all others to zero
  localparam coef_arr_t COEF_RST = {
    48'h0000_0000_0000,  // coef_5
    48'h0000_0000_0000,  // coef_4
    48'h0000_0000_0000,  // coef_3
    48'h0000_0000_0000,  // coef_2
    48'h0100_0000_0000,  // coef_1
    48'h0000_0000_0000   // coef_0
  };

endpackage

### rtl/ppc_cfg_regs.sv
// Coefficient register file behind an APB-style port.
// Depends on ppc_pkg.
module ppc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppc_pkg::ADDR_W-1:0]        paddr,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ppc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output ppc_pkg::coef_arr_t                coef
);

  ppc_pkg::coef_arr_t             coef_r;
  logic [ppc_pkg::IDX_W-1:0]      idx;
  logic                           idx_ok;
  logic                           wr;

  assign idx    = paddr[ppc_pkg::ADDR_W-1:3];
  assign idx_ok = idx < ppc_pkg::IDX_W'(ppc_pkg::NUM_REGS);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= ppc_pkg::COEF_RST;
    end else if (wr && idx_ok) begin
      coef_r[idx] <= pwdata[ppc_pkg::COEF_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = ppc_pkg::CFG_DATA_W'(coef_r[idx]);
    end
  end

  assign coef = coef_r;

endmodule

### rtl/ppc_horner_step.sv
// One Horner step h' = h * v + c: partial-product stage then add stage.
// Depends on ppc_pkg.
module ppc_horner_step #(
  parameter int AW = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_take,
  input  logic [AW-1:0]             in_h,
  input  logic [ppc_pkg::PIX_W-1:0] in_pix,
  input  logic [AW-1:0]             cterm,
  output logic                      out_valid,
  input  logic                      out_take,
  output logic [AW-1:0]             out_h,
  output logic [ppc_pkg::PIX_W-1:0] out_pix
);

  localparam int NCH  = AW / 32;
  localparam int PP_W = 32 + ppc_pkg::PIX_W;

  logic                      va_r, vb_r;
  logic                      en_a, en_b;
  logic [AW-1:0]             evens_r, odds_r, evens_nxt, odds_nxt;
  logic [AW-1:0]             h_r, h_nxt;
  logic [ppc_pkg::PIX_W-1:0] pix_a_r, pix_b_r;

  assign en_b    = !vb_r || out_take;
  assign en_a    = !va_r || en_b;
  assign in_take = en_a;

  // h is taken as unsigned over AW bits: the product is exact modulo 2^AW,
  // and the true signed product fits in AW bits.
  // 48-bit partial products at a 32-bit pitch: even ones never overlap each other, nor do odd ones.
  always_comb begin
    logic [AW+ppc_pkg::PIX_W-1:0] ev, od;
    logic [PP_W-1:0]              pp;
    ev = '0;
    od = '0;
    for (int c = 0; c < NCH; c++) begin
      pp = in_h[32*c +: 32] * in_pix;
      if (c % 2 == 0) begin
        ev[32*c +: PP_W] = pp;
      end else begin
        od[32*c +: PP_W] = pp;
      end
    end
    evens_nxt = ev[AW-1:0];
    odds_nxt  = od[AW-1:0];
  end

  assign h_nxt = evens_r + odds_r + cterm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      evens_r <= evens_nxt;
      odds_r  <= odds_nxt;
      pix_a_r <= in_pix;
    end
    if (en_b) begin
      h_r     <= h_nxt;
      pix_b_r <= pix_a_r;
    end
  end

  assign out_valid = vb_r;
  assign out_h     = h_r;
  assign out_pix   = pix_b_r;

endmodule

### rtl/ppc_clip.sv
// Truncation toward zero and clipping to 0..65535, range stage then output register.
// Depends on ppc_pkg.
module ppc_clip #(
  parameter int AW     = 128,
  parameter int FRAC_W = 72
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_take,
  input  logic [AW-1:0]             in_h,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ppc_pkg::PIX_W-1:0] out_pixel_out,
  output logic                      out_clipped
);

  typedef struct packed {
    logic                      neg;
    logic                      up_ones;   // integer part is all ones
    logic                      hi_any;    // integer part needs more than 16 bits
    logic                      frac_nz;
    logic [ppc_pkg::PIX_W-1:0] low;
  } range_t;

  logic                      vr_r, vo_r;
  logic                      en_r, en_o;
  range_t                    rng_r, rng_nxt;
  logic [ppc_pkg::PIX_W-1:0] pix_r, pix_nxt;
  logic                      clip_r, clip_nxt;

  assign en_o    = !vo_r || !out_stall;
  assign en_r    = !vr_r || en_o;
  assign in_take = en_r;

  always_comb begin
    rng_nxt.neg     = in_h[AW-1];
    rng_nxt.up_ones = &in_h[AW-1:FRAC_W];
    rng_nxt.hi_any  = |in_h[AW-1:FRAC_W+ppc_pkg::PIX_W];
    rng_nxt.frac_nz = |in_h[FRAC_W-1:0];
    rng_nxt.low     = in_h[FRAC_W +: ppc_pkg::PIX_W];
  end

  // a value in (-1, 0) truncates to zero and is not a clip
  always_comb begin
    if (rng_r.neg) begin
      pix_nxt  = '0;
      clip_nxt = !(rng_r.up_ones && rng_r.frac_nz);
    end else if (rng_r.hi_any) begin
      pix_nxt  = '1;
      clip_nxt = 1'b1;
    end else begin
      pix_nxt  = rng_r.low;
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en_r) vr_r <= in_valid;
      if (en_o) vo_r <= vr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_r) rng_r <= rng_nxt;
    if (en_o) begin
      pix_r  <= pix_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_valid     = vo_r;
  assign out_pixel_out = pix_r;
  assign out_clipped   = clip_r;

endmodule

### rtl/pixel_polynomial_correction_top.sv
// Path from input accept to out_valid: entry register, Horner steps, clip stage.
// Throughput: one item per cycle; each Horner step is a partial-product stage
// and an add stage, with stalls absorbed stage by stage.
// Reset: rst_n synchronous active low; clears all valid bits and loads the
// coefficient reset values. Uses ppc_pkg, ppc_cfg_regs, ppc_horner_step, ppc_clip.
module pixel_polynomial_correction_top #(
  parameter int NUM_COEFFS = ppc_pkg::NUM_COEFFS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ppc_pkg::PIX_W-1:0]       in_pixel_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ppc_pkg::PIX_W-1:0]       out_pixel_out,
  output logic                            out_clipped,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppc_pkg::ADDR_W-1:0]      paddr,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ppc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int NSTEP  = NUM_COEFFS - 1;
  // magnitude bound of the Horner sum plus sign, then room for one more x v
  localparam int HW     = ppc_pkg::COEF_W + 3 + ppc_pkg::STEP_SHIFT * NSTEP;
  localparam int AW     = 32 * ((HW + ppc_pkg::PIX_W + 31) / 32);
  localparam int FRAC_W = ppc_pkg::COEF_FRAC_W + ppc_pkg::STEP_SHIFT * NSTEP;

  ppc_pkg::coef_arr_t        coef;

  logic                      vld  [NSTEP+1];
  logic                      take [NSTEP+1];
  logic [AW-1:0]             h    [NSTEP+1];
  logic [ppc_pkg::PIX_W-1:0] pix  [NSTEP+1];

  logic                      vld0_r;
  logic                      en0;
  logic [AW-1:0]             h0_r, h0_nxt;
  logic [ppc_pkg::PIX_W-1:0] pix0_r;

  ppc_cfg_regs u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .coef
  );

  // entry stage: Horner starts from the top coefficient; with one coefficient
  // the sum is coef_0 plus the pixel at unit slope
  always_comb begin
    h0_nxt = {{(AW-ppc_pkg::COEF_W){coef[NUM_COEFFS-1][ppc_pkg::COEF_W-1]}},
              coef[NUM_COEFFS-1]};
    if (NUM_COEFFS == 1) begin
      h0_nxt = h0_nxt + (AW'(in_pixel_in) << ppc_pkg::COEF_FRAC_W);
    end
  end

  assign en0      = !vld0_r || take[0];
  assign in_stall = !en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en0) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      h0_r   <= h0_nxt;
      pix0_r <= in_pixel_in;
    end
  end

  assign vld[0] = vld0_r;
  assign h[0]   = h0_r;
  assign pix[0] = pix0_r;

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int K = NUM_COEFFS - 2 - j;
    logic [AW-1:0] cterm;

    assign cterm = {{(AW-ppc_pkg::COEF_W){coef[K][ppc_pkg::COEF_W-1]}}, coef[K]}
                   << (ppc_pkg::STEP_SHIFT * (j + 1));

    ppc_horner_step #(.AW(AW)) u_step (
      .clk,
      .rst_n,
      .in_valid  (vld[j]),
      .in_take   (take[j]),
      .in_h      (h[j]),
      .in_pix    (pix[j]),
      .cterm     (cterm),
      .out_valid (vld[j+1]),
      .out_take  (take[j+1]),
      .out_h     (h[j+1]),
      .out_pix   (pix[j+1])
    );
  end

  ppc_clip #(.AW(AW), .FRAC_W(FRAC_W)) u_clip (
    .clk,
    .rst_n,
    .in_valid      (vld[NSTEP]),
    .in_take       (take[NSTEP]),
    .in_h          (h[NSTEP]),
    .out_valid,
    .out_stall,
    .out_pixel_out,
    .out_clipped
  );

endmodule

### rtl/ppc_checker.sv
// Port-level checks for the pixel polynomial correction block, bound to the top.
// Depends on ppc_pkg and pixel_polynomial_correction_top.
module ppc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ppc_pkg::PIX_W-1:0]       out_pixel_out,
  input logic                            out_clipped,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [ppc_pkg::ADDR_W-1:0]      paddr,
  input logic [ppc_pkg::CFG_DATA_W-1:0]  pwdata,
  input logic [ppc_pkg::CFG_DATA_W-1:0]  prdata,
  input logic                            pready
);

  logic cfg_wr, cfg_rd, idx_ok;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign cfg_rd = psel & !pwrite;
  assign idx_ok = paddr[ppc_pkg::ADDR_W-1:3] < ppc_pkg::IDX_W'(ppc_pkg::NUM_REGS);

  // a held item keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) && $stable(out_clipped))
    else $error("output item changed while stalled");

  // a clipped item sits at one end of the range
  a_clip_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_pixel_out == '0 || out_pixel_out == '1)
    else $error("clipped item not at a range end");

  // with the output stage empty the pipeline must take a new item
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  // a coefficient written is read back
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && idx_ok ##1 cfg_rd && paddr == $past(paddr) |->
      prdata[ppc_pkg::COEF_W-1:0] == $past(pwdata[ppc_pkg::COEF_W-1:0]))
    else $error("coefficient readback mismatch");

endmodule

bind pixel_polynomial_correction_top ppc_checker u_ppc_checker (.*);
